/* hdl/bped_pkg.sv */
package bped_pkg;

   localparam int TIME_W    = 32;
   localparam int HOLDOFF_W = 16;

   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd50;

   // What the merging stage tells one lane at an accepted beat.
   typedef struct packed {
      logic update;   // take the current level as the previous level
      logic store;    // this lane is reported; keep the timestamp
   } lane_ctrl_type;

endpackage

/* hdl/bped_if.sv */
interface bped_req_if
   import bped_pkg::*;
#(
   parameter int LINE_COUNT = 5
) ();
   logic                  valid;
   logic                  ready;
   logic [LINE_COUNT-1:0] line_levels;
   logic [TIME_W-1:0]     now_ms;

   modport source (output valid, line_levels, now_ms, input ready);
   modport sink   (input valid, line_levels, now_ms, output ready);
endinterface

interface bped_rsp_if
#(
   parameter int LINE_COUNT = 5
) ();
   localparam int CODE_W = $clog2(LINE_COUNT + 1);

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] event_code;

   modport source (output valid, event_code, input ready);
   modport sink   (input valid, event_code, output ready);
endinterface

interface bped_csr_if
   import bped_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [HOLDOFF_W-1:0] holdoff_ms;

   modport source (output valid, holdoff_ms, input ready);
   modport sink   (input valid, holdoff_ms, output ready);
endinterface

/* hdl/button_press_edge_debounce_unit.sv */
// An accepted poll's event code is registered onto rsp_port. Throughput: one poll per clock
// unless a result beat stalls; every line's subtract and compare runs in its own lane and
// the priority merge completes in the same cycle, so line history is current for the next poll.
// Reset is synchronous and active high: all previous levels and press times clear to zero,
// the hold-off returns to 50 ms and the output register empties.
module button_press_edge_debounce_unit
   import bped_pkg::*;
#(
   parameter int LINE_COUNT = 5
) (
   input  logic       clock,
   input  logic       reset,
   bped_req_if.sink   req_port,
   bped_rsp_if.source rsp_port,
   bped_csr_if.sink   csr_port
);

   localparam int CODE_W = $clog2(LINE_COUNT + 1);

   logic [HOLDOFF_W-1:0]  holdoff_ff;
   logic [HOLDOFF_W-1:0]  holdoff_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CODE_W-1:0]     code_ff;
   logic [CODE_W-1:0]     code_in;
   logic                  fire;
   logic [LINE_COUNT-1:0] hit;
   lane_ctrl_type         ctrl [LINE_COUNT];
   logic [CODE_W-1:0]     merge_code;

   assign csr_port.ready = 1'b1;
   assign holdoff_in     = csr_port.valid ? csr_port.holdoff_ms : holdoff_ff;

   // A new beat is taken whenever the output register is empty or being drained.
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign fire           = req_port.valid && req_port.ready;

   genvar g;
   generate
      for (g = 0; g < LINE_COUNT; g++) begin : g_lane
         bped_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .level      (req_port.line_levels[g]),
            .now_ms     (req_port.now_ms),
            .holdoff_ms (holdoff_ff),
            .ctrl       (ctrl[g]),
            .hit        (hit[g])
         );
      end
   endgenerate

   bped_merge #(
      .LINE_COUNT (LINE_COUNT),
      .CODE_W     (CODE_W)
   ) u_merge (
      .fire       (fire),
      .hit        (hit),
      .ctrl       (ctrl),
      .event_code (merge_code)
   );

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_port.ready);
   assign code_in      = fire ? merge_code : code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff   <= HOLDOFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         holdoff_ff   <= holdoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff <= code_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.event_code = code_ff;

endmodule

/* hdl/bped_lane.sv */
module bped_lane
   import bped_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 level,
   input  logic [TIME_W-1:0]    now_ms,
   input  logic [HOLDOFF_W-1:0] holdoff_ms,
   input  lane_ctrl_type        ctrl,
   output logic                 hit
);

   logic              prev_ff;
   logic              prev_in;
   logic [TIME_W-1:0] last_ff;
   logic [TIME_W-1:0] last_in;
   logic [TIME_W-1:0] elapsed;

   // Wrapping difference, so a timestamp that runs backwards looks very old.
   assign elapsed = now_ms - last_ff;
   assign hit     = level && !prev_ff
                    && (elapsed >= {{(TIME_W - HOLDOFF_W){1'b0}}, holdoff_ms});

   assign prev_in = ctrl.update ? level  : prev_ff;
   assign last_in = ctrl.store  ? now_ms : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
         last_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         last_ff <= last_in;
      end
   end

endmodule

/* hdl/bped_merge.sv */
module bped_merge
   import bped_pkg::*;
#(
   parameter int LINE_COUNT = 5,
   parameter int CODE_W     = 3
) (
   input  logic                  fire,
   input  logic [LINE_COUNT-1:0] hit,
   output lane_ctrl_type         ctrl [LINE_COUNT],
   output logic [CODE_W-1:0]     event_code
);

   logic [LINE_COUNT:0] seen;

   // The lowest lane with a hit wins; lanes above it keep their history.
   always_comb begin
      seen[0]    = 1'b0;
      event_code = '0;
      for (int i = 0; i < LINE_COUNT; i++) begin
         ctrl[i].update = fire && !seen[i];
         ctrl[i].store  = fire && hit[i] && !seen[i];
         if (hit[i] && !seen[i]) begin
            event_code = CODE_W'(i + 1);
         end
         seen[i+1] = seen[i] | hit[i];
      end
   end

endmodule

/* hdl/bped_checker.sv */
module bped_checker #(
   parameter int LINE_COUNT = 5,
   parameter int CODE_W     = 3
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CODE_W-1:0] rsp_event_code
);

   // The output register is empty straight after reset.
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat offered straight after reset");

   // Every accepted poll produces a result beat on the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted poll produced no result beat");

   // A stalled result blocks further polls.
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("poll accepted while a result beat is stalled");

   // Event codes never name a line that does not exist.
   a_code_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_code <= CODE_W'(LINE_COUNT))
      else $error("event code beyond the last line");

   // A stalled result beat holds its code.
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code))
      else $error("stalled result beat changed");

endmodule

bind button_press_edge_debounce_unit bped_checker #(
   .LINE_COUNT (LINE_COUNT),
   .CODE_W     ($clog2(LINE_COUNT + 1))
) u_bped_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_event_code (rsp_port.event_code)
);

/* tb/bped_press_checker.sv */
module bped_press_checker
   import bped_pkg::*;
#(
   parameter int LINE_COUNT = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [LINE_COUNT-1:0]              req_line_levels,
   input  logic [TIME_W-1:0]                  req_now_ms,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [$clog2(LINE_COUNT + 1)-1:0]  rsp_event_code,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [HOLDOFF_W-1:0]               csr_holdoff_ms,
   output int                                 fail_count,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CODE_W = $clog2(LINE_COUNT + 1);
   localparam logic [CODE_W-1:0] NO_EVENT = '0;
   localparam int REPORT_LIMIT = 10;

   logic [LINE_COUNT-1:0] line_was_pressed;
   logic [TIME_W-1:0]     press_stamp [LINE_COUNT];
   logic [HOLDOFF_W-1:0]  holdoff;
   logic [CODE_W-1:0]     expected_codes [$];
   logic [CODE_W-1:0]     oldest_code;

   // Scans the lines from the lowest index and stops at the first accepted press, so
   // the lines above it keep the level they had before this poll.
   function automatic logic [CODE_W-1:0] predict_event_code(
      input logic [LINE_COUNT-1:0] levels,
      input logic [TIME_W-1:0]     now
   );
      logic [TIME_W-1:0] elapsed;
      for (int i = 0; i < LINE_COUNT; i++) begin
         elapsed = now - press_stamp[i];
         if (levels[i] && !line_was_pressed[i] && elapsed >= TIME_W'(holdoff)) begin
            line_was_pressed[i] = 1'b1;
            press_stamp[i] = now;
            return CODE_W'(i + 1);
         end
         line_was_pressed[i] = levels[i];
      end
      return NO_EVENT;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         line_was_pressed = '0;
         foreach (press_stamp[i]) press_stamp[i] = '0;
         holdoff = HOLDOFF_RESET;
         expected_codes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            holdoff = csr_holdoff_ms;
         end
         // The result beat is matched before this edge's poll is predicted, so a result
         // cannot pair with a poll accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t: event code %0d arrived with no poll waiting for it",
                           $realtime, rsp_event_code);
               end
               fail_count++;
            end else begin
               oldest_code = expected_codes.pop_front();
               if (rsp_event_code !== oldest_code) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: event code mismatch, expected %0d, got %0d",
                              $realtime, oldest_code, rsp_event_code);
                  end
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_codes.push_back(predict_event_code(req_line_levels, req_now_ms));
         end
      end
      pending = expected_codes.size();
   end

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bped_pkg::*;

   localparam int LINE_COUNT       = 5;
   localparam int STALL_LIMIT      = 5000;
   localparam int NUM_PHASES       = 6;
   localparam int POLLS_PER_PHASE  = 172;
   localparam int SETTLE_CYCLES    = 5;

   logic                  clock;
   logic                  reset;
   int                    fail_count;
   int                    pending;
   int                    send_gap_pct = 11;
   int                    recv_stall_pct = 75;
   int                    quiet_cycles = 0;
   logic [TIME_W-1:0]     poll_time;
   logic [LINE_COUNT-1:0] poll_levels;

   bped_req_if #(.LINE_COUNT(LINE_COUNT)) req_bus ();
   bped_rsp_if #(.LINE_COUNT(LINE_COUNT)) rsp_bus ();
   bped_csr_if csr_bus ();

   button_press_edge_debounce_unit #(.LINE_COUNT(LINE_COUNT)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   bped_press_checker #(.LINE_COUNT(LINE_COUNT)) u_press_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_line_levels (req_bus.line_levels),
      .req_now_ms      (req_bus.now_ms),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_event_code  (rsp_bus.event_code),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_bus.ready),
      .csr_holdoff_ms  (csr_bus.holdoff_ms),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat, with valid
   // still high so that a following poll can go out without a gap.
   task automatic send_poll(input logic [LINE_COUNT-1:0] levels, input logic [TIME_W-1:0] now);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.line_levels <= levels;
      req_bus.now_ms      <= now;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_holdoff(input logic [HOLDOFF_W-1:0] value);
      wait_drained();
      csr_bus.valid      <= 1'b1;
      csr_bus.holdoff_ms <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Time mostly creeps forward in steps well inside the hold-off, so that presses land
   // both inside and outside the lockout; now and then it jumps, goes backwards or wraps.
   task automatic random_polls(input int count, input int hold);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99, 0);
         if (pick < 5) begin
            poll_time = $urandom();
         end else if (pick < 8) begin
            poll_time = 32'hFFFF_FFFF - TIME_W'($urandom_range(2 * hold + 2, 0));
         end else begin
            poll_time = poll_time + TIME_W'($urandom_range(hold / 4 + 2, 0));
         end
         pick = $urandom_range(99, 0);
         if (pick < 65) begin
            poll_levels ^= LINE_COUNT'(1) << $urandom_range(LINE_COUNT - 1, 0);
         end else if (pick < 85) begin
            poll_levels = LINE_COUNT'($urandom());
         end else if (pick < 92) begin
            poll_levels = '0;
         end
         send_poll(poll_levels, poll_time);
         if ($urandom_range(99, 0) == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin : stimulus
      int hold;
      req_bus.valid       = 1'b0;
      req_bus.line_levels = '0;
      req_bus.now_ms      = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.holdoff_ms  = '0;
      poll_time           = '0;
      poll_levels         = '0;
      reset               = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hold-off is still at its reset value here, and every press time is zero.
      send_poll(5'b00001, 32'd10);         // too soon after reset, suppressed
      send_poll(5'b00000, 32'd20);
      send_poll(5'b00001, 32'd60);
      send_poll(5'b00000, 32'd70);
      send_poll(5'b00001, 32'd109);        // one short of the hold-off
      send_poll(5'b00000, 32'd110);
      send_poll(5'b00001, 32'd110);        // exactly the hold-off
      send_poll(5'b11111, 32'd200);        // lines above the reported one keep their level
      send_poll(5'b11111, 32'd201);
      send_poll(5'b11111, 32'd202);
      send_poll(5'b11111, 32'd203);
      send_poll(5'b11111, 32'd204);
      send_poll(5'b00000, 32'd0);          // time goes backwards
      send_poll(5'b11111, 32'hFFFF_FFFF);
      send_poll(5'b11110, 32'd0);          // elapsed time wraps round
      send_poll(5'b00000, 32'd5);
      write_holdoff('0);
      send_poll(5'b00001, 32'hFFFF_FFFF);
      send_poll(5'b00000, 32'hFFFF_FFFF);
      send_poll(5'b00001, 32'hFFFF_FFFF);  // same instant, no lockout at all

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_gap_pct   = 11;
               recv_stall_pct = 75;
            end
            1: begin
               send_gap_pct   = 75;
               recv_stall_pct = 11;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         case (phase)
            0:       hold = 65535;
            1:       hold = 0;
            2:       hold = 3;
            3:       hold = $urandom_range(65535, 0);
            4:       hold = 1000;
            default: hold = 50;
         endcase
         write_holdoff(HOLDOFF_W'(hold));
         random_polls(POLLS_PER_PHASE, hold);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/bped_pkg.sv
hdl/bped_if.sv
hdl/bped_lane.sv
hdl/bped_merge.sv
hdl/button_press_edge_debounce_unit.sv
hdl/bped_checker.sv
tb/bped_press_checker.sv
tb/tb_top.sv
